// File: src/sgr_pkg.sv
`default_nettype none

package sgr_pkg;

  // The node count register and the row field keep fixed widths whatever MAX_NODES is.
  localparam int unsigned NodeCountW     = 7;
  localparam int unsigned RowW           = 64;
  localparam logic [NodeCountW-1:0] NodeCountReset = 7'd64;

endpackage

`default_nettype wire

// File: src/sgr_ram.sv
`default_nettype none

module sgr_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: src/stack_graph_reachability.sv
`default_nettype none

// Loads an adjacency matrix one row per input transaction (one row per cycle, rows
// beyond MAX_NODES are dropped) and, after the row flagged last_row, runs a
// stack-based search from node 0 and returns one transaction whose reachable flag
// tells whether node n-1 was reached, n being node_count clamped to 1..MAX_NODES.
// The search holds the input stalled; it takes a start step, one adjacency read
// per pass, one push step per node pushed and one extra stack read step per pop,
// a sequence set by the single read port of the adjacency memory and the single
// write port of the stack memory. node_count may only be written while no search
// is running.
module stack_graph_reachability
  import sgr_pkg::*;
#(
  parameter int unsigned MAX_NODES = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [NodeCountW-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [RowW-1:0]       row_bits_i,
  input  wire logic                  last_row_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       reachable_o
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned DW = $clog2(MAX_NODES + 1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_EVAL,
    ST_POP,
    ST_PUSH,
    ST_FINISH
  } state_e;

  state_e                  state_q;
  logic [NodeCountW-1:0]   node_count_q;
  logic [DW-1:0]           row_cnt_q;
  logic [DW-1:0]           depth_q;
  logic [MAX_NODES-1:0]    visited_q;
  logic [MAX_NODES-1:0]    pend_q;
  logic                    result_q;
  logic                    out_valid_q;
  logic                    reach_q;

  logic                    adj_we;
  logic [IW-1:0]           adj_waddr;
  logic [IW-1:0]           adj_raddr;
  logic [MAX_NODES-1:0]    adj_rdata;
  logic                    stk_we;
  logic [IW-1:0]           stk_waddr;
  logic [IW-1:0]           stk_wdata;
  logic [IW-1:0]           stk_raddr;
  logic [IW-1:0]           stk_rdata;

  logic [DW-1:0]           n_eff;
  logic [DW-1:0]           n_m1;
  logic [IW-1:0]           last_idx;
  logic [MAX_NODES-1:0]    colmask;
  logic [MAX_NODES-1:0]    new_nbrs;
  logic [IW-1:0]           push_node;
  logic [MAX_NODES-1:0]    pend_left;
  logic [DW-1:0]           depth_m2;
  logic                    row_room;

  function automatic logic [IW-1:0] lowest_set(input logic [MAX_NODES-1:0] v);
    logic [IW-1:0] idx;
    idx = '0;
    for (int j = MAX_NODES - 1; j >= 0; j--) begin
      if (v[j]) begin
        idx = IW'(j);
      end
    end
    return idx;
  endfunction

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = DW'(1);
    end else if (node_count_q > NodeCountW'(MAX_NODES)) begin
      n_eff = DW'(MAX_NODES);
    end else begin
      n_eff = node_count_q[DW-1:0];
    end
  end

  assign n_m1     = n_eff - DW'(1);
  assign last_idx = n_m1[IW-1:0];

  always_comb begin
    for (int j = 0; j < MAX_NODES; j++) begin
      colmask[j] = (DW'(j) < n_eff);
    end
  end

  assign new_nbrs  = adj_rdata & colmask & ~visited_q;
  assign push_node = lowest_set(pend_q);
  assign pend_left = pend_q & ~(MAX_NODES'(1) << push_node);
  assign depth_m2  = depth_q - DW'(2);
  assign row_room  = (row_cnt_q < DW'(MAX_NODES));

  always_comb begin
    adj_we    = (state_q == ST_LOAD) && in_valid_i && row_room;
    adj_waddr = row_cnt_q[IW-1:0];
    stk_we    = 1'b0;
    stk_waddr = depth_q[IW-1:0];
    stk_wdata = push_node;
    stk_raddr = depth_m2[IW-1:0];
    case (state_q)
      ST_START: begin
        adj_raddr = '0;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = '0;
      end
      ST_POP: begin
        adj_raddr = stk_rdata;
      end
      ST_PUSH: begin
        adj_raddr = push_node;
        stk_we    = 1'b1;
      end
      default: begin
        adj_raddr = '0;
      end
    endcase
  end

  sgr_ram #(
    .WIDTH(MAX_NODES),
    .DEPTH(MAX_NODES)
  ) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(row_bits_i[MAX_NODES-1:0]),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rdata)
  );

  sgr_ram #(
    .WIDTH(IW),
    .DEPTH(MAX_NODES)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      node_count_q <= NodeCountReset;
      row_cnt_q    <= '0;
      depth_q      <= '0;
      visited_q    <= '0;
      pend_q       <= '0;
      result_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      reach_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (state_q == ST_FINISH && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_LOAD: begin
          if (in_valid_i) begin
            if (last_row_i) begin
              row_cnt_q <= '0;
              state_q   <= ST_START;
            end else if (row_room) begin
              row_cnt_q <= row_cnt_q + DW'(1);
            end
          end
        end
        ST_START: begin
          visited_q <= MAX_NODES'(1);
          depth_q   <= DW'(1);
          state_q   <= ST_EVAL;
        end
        ST_EVAL: begin
          // A single node is its own target, so only a self-loop reaches it.
          if (n_eff == DW'(1)) begin
            result_q <= adj_rdata[0];
            state_q  <= ST_FINISH;
          end else if (new_nbrs[last_idx]) begin
            result_q <= 1'b1;
            state_q  <= ST_FINISH;
          end else if (new_nbrs == '0) begin
            depth_q <= depth_q - DW'(1);
            if (depth_q == DW'(1)) begin
              result_q <= 1'b0;
              state_q  <= ST_FINISH;
            end else begin
              state_q <= ST_POP;
            end
          end else begin
            pend_q    <= new_nbrs;
            visited_q <= visited_q | new_nbrs;
            state_q   <= ST_PUSH;
          end
        end
        ST_POP: begin
          state_q <= ST_EVAL;
        end
        ST_PUSH: begin
          // Neighbors go on in ascending order, so the highest one ends up on top.
          depth_q <= depth_q + DW'(1);
          pend_q  <= pend_left;
          if (pend_left == '0) begin
            state_q <= ST_EVAL;
          end
        end
        ST_FINISH: begin
          if (!out_valid_q || !out_stall_i) begin
            reach_q <= result_q;
            state_q <= ST_LOAD;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_LOAD);
  assign out_valid_o = out_valid_q;
  assign reachable_o = reach_q;

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(MAX_NODES))
    else $error("stack depth exceeds the number of nodes");

  a_push_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PUSH) |-> (pend_q != '0))
    else $error("push cycle without a pending neighbor");

  a_eval_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL || state_q == ST_POP) |-> (depth_q != '0))
    else $error("stack pass with an empty stack");

  a_start_visited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL || state_q == ST_PUSH || state_q == ST_POP) |-> visited_q[0])
    else $error("start node not marked visited during the search");

  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result transaction raised outside the finish step");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import sgr_pkg::*;

  localparam int MaxNodes = 64;
  localparam int QuietAfter = 1200;
  localparam int TargetRows = 1400;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [NodeCountW-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [RowW-1:0]       row_bits_i;
  logic                  last_row_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  reachable_o;

  stack_graph_reachability #(.MAX_NODES(MaxNodes)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .row_bits_i (row_bits_i),
    .last_row_i (last_row_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .reachable_o(reachable_o)
  );

  typedef struct packed {
    logic                  is_cfg;
    logic [NodeCountW-1:0] cfg_val;
    logic [RowW-1:0]       row;
    logic                  last;
    logic                  has_exp;
    logic                  exp_reach;
  } stim_t;

  localparam int DirCount = 23;
  localparam stim_t DirStim [DirCount] = '{
    // Reset node count of 64, only row 0 is read.
    '{1'b0, 7'd0,   64'h0000_0000_0000_0001, 1'b1, 1'b1, 1'b0},
    '{1'b0, 7'd0,   64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1},
    // A zero node count means one node: only a self-loop makes it reachable.
    '{1'b1, 7'd0,   64'h0,                   1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0001, 1'b1, 1'b1, 1'b1},
    '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 1'b1, 1'b0},
    // Counts above 64 clamp to 64.
    '{1'b1, 7'd127, 64'h0,                   1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h8000_0000_0000_0000, 1'b1, 1'b1, 1'b1},
    // Columns at and above the node count are ignored.
    '{1'b1, 7'd3,   64'h0,                   1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0002, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FFF8, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
    // Early last row: row 2 keeps its earlier contents.
    '{1'b0, 7'd0,   64'h0000_0000_0000_0002, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0004, 1'b1, 1'b1, 1'b1},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0002, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0001, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0003, 1'b1, 1'b1, 1'b0},
    // Rows stored beyond the node count play no part.
    '{1'b1, 7'd2,   64'h0,                   1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FFFC, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0001, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0000, 1'b1, 1'b1, 1'b0},
    '{1'b1, 7'd3,   64'h0,                   1'b0, 1'b0, 1'b0},
    '{1'b0, 7'd0,   64'h0000_0000_0000_0004, 1'b1, 1'b1, 1'b1}
  };

  // Shadow of the block, updated on accepted transactions.
  logic [RowW-1:0]       adj_rows [MaxNodes];
  int                    rows_loaded;
  logic [NodeCountW-1:0] node_count_q;
  logic                  expected_reach_q [$];
  int                    failures;

  // Stimulus-side bookkeeping, so that no search reads a row never written.
  logic [MaxNodes-1:0]   gen_written;
  int                    gen_rows;
  int                    gen_nodes;
  int                    items_sent;
  logic                  long_hold_done;
  logic                  typed_given;
  logic                  typed_reach;
  logic                  quiet;

  assign quiet = (items_sent >= QuietAfter);

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic reach_from_first();
    int                  n;
    int                  sp;
    logic [RowW-1:0]     colmask;
    logic [RowW-1:0]     seen;
    logic [RowW-1:0]     row;
    logic [5:0]          stk [MaxNodes];
    logic                done;
    logic                pushed;
    n = (node_count_q == 0) ? 1 : ((node_count_q > MaxNodes) ? MaxNodes : int'(node_count_q));
    colmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    seen = 64'd1;
    stk[0] = 6'd0;
    sp = 1;
    done = (n == 1) && adj_rows[0][0];
    do begin
      row = adj_rows[stk[sp-1]] & colmask;
      pushed = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (row[j] && !seen[j]) begin
          if (sp < MaxNodes) begin
            stk[sp] = 6'(j);
            sp++;
          end
          seen[j] = 1'b1;
          pushed = 1'b1;
          if (j == n - 1) done = 1'b1;
        end
      end
      if (!pushed) sp--;
    end while (!done && sp != 0);
    return done;
  endfunction

  function automatic logic [RowW-1:0] make_row(input int mode, input int idx, input int n);
    logic [RowW-1:0] colmask;
    logic [RowW-1:0] noise;
    logic [RowW-1:0] row;
    colmask = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    noise = {$urandom, $urandom};
    row = '0;
    case (mode)
      0: row = noise;
      1: begin
        repeat ($urandom_range(0, 2)) row[$urandom_range(0, n - 1)] = 1'b1;
        row |= noise & ~colmask;
      end
      2: begin
        // A chain through all nodes drives the stack to its full depth.
        if (idx + 1 < n && $urandom_range(0, 15) != 0) row[idx+1] = 1'b1;
        row |= noise & ~colmask;
      end
      3: row = $urandom_range(0, 1) ? '1 : '0;
      default: row = noise & {$urandom, $urandom};
    endcase
    return row;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) node_count_q = cfg_wdata_i;
      if (out_valid_o && !out_stall_i) begin
        if (expected_reach_q.size() == 0) begin
          $error("reachable: no result expected, actual %0b", reachable_o);
          failures++;
        end else begin
          if (reachable_o !== expected_reach_q[0]) begin
            $error("reachable mismatch: expected %0b, actual %0b",
                   expected_reach_q[0], reachable_o);
            failures++;
          end
          void'(expected_reach_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        if (rows_loaded < MaxNodes) begin
          adj_rows[rows_loaded] = row_bits_i;
          rows_loaded++;
        end
        if (last_row_i) begin
          if (typed_given) begin
            void'(reach_from_first());
            expected_reach_q.push_back(typed_reach);
          end else begin
            expected_reach_q.push_back(reach_from_first());
          end
          rows_loaded = 0;
        end
      end
    end
  end

  task automatic send_row(input logic [RowW-1:0] row, input logic last,
                          input logic typed, input logic exp_val);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    row_bits_i  <= row;
    last_row_i  <= last;
    typed_given <= typed;
    typed_reach <= exp_val;
    if (gen_rows < MaxNodes) begin
      gen_written[gen_rows] = 1'b1;
      gen_rows++;
    end
    if (last) gen_rows = 0;
    items_sent++;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Called at a falling edge; the node count only changes with the block idle.
  task automatic set_node_count(input logic [NodeCountW-1:0] value);
    in_valid_i <= 1'b0;
    while (expected_reach_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    gen_nodes = (value == 0) ? 1 : ((value > MaxNodes) ? MaxNodes : int'(value));
  endtask

  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && items_sent >= 300) begin
        // Hold results back long enough for the input side to back up.
        long_hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (300) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int                    n;
    int                    k;
    int                    k_min;
    int                    mode;
    int                    round;
    logic [NodeCountW-1:0] ncv;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    row_bits_i     = '0;
    last_row_i     = 1'b0;
    typed_given    = 1'b0;
    typed_reach    = 1'b0;
    rows_loaded    = 0;
    node_count_q   = NodeCountReset;
    failures       = 0;
    gen_written    = '0;
    gen_rows       = 0;
    gen_nodes      = MaxNodes;
    items_sent     = 0;
    long_hold_done = 1'b0;
    for (int i = 0; i < MaxNodes; i++) adj_rows[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirCount; i++) begin
      if (DirStim[i].is_cfg) set_node_count(DirStim[i].cfg_val);
      else send_row(DirStim[i].row, DirStim[i].last, DirStim[i].has_exp, DirStim[i].exp_reach);
    end

    round = 0;
    while (items_sent < TargetRows) begin
      if (round == 0 || $urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 9))
          0:       ncv = 7'd0;
          1:       ncv = 7'd1;
          2:       ncv = 7'd64;
          3:       ncv = 7'd127;
          4:       ncv = 7'($urandom_range(65, 126));
          5:       ncv = 7'($urandom_range(13, 63));
          default: ncv = 7'($urandom_range(2, 12));
        endcase
        set_node_count(ncv);
      end
      n = gen_nodes;
      // Rows this round must cover every row in use that was never written.
      k_min = 1;
      for (int i = 0; i < n; i++) if (!gen_written[i]) k_min = i + 1;
      k = n;
      case ($urandom_range(0, 7))
        0: k = $urandom_range(k_min, n);
        1: if (n <= MaxNodes - 2) k = n + $urandom_range(1, 2);
        2: if (n == MaxNodes) k = $urandom_range(MaxNodes + 1, MaxNodes + 3);
        default: k = n;
      endcase
      mode = $urandom_range(0, 4);
      for (int i = 0; i < k; i++) send_row(make_row(mode, i, n), i == k - 1, 1'b0, 1'b0);
      round++;
    end
    in_valid_i <= 1'b0;

    while (expected_reach_q.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (expected_reach_q.size() != 0) begin
      $error("reachable: %0d results never arrived", expected_reach_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
src/sgr_pkg.sv
src/sgr_ram.sv
src/stack_graph_reachability.sv
tb/tb.sv
